// File: rtl/mcd_pkg.sv
// Shared types and constants for the microcoded datapath cycle unit.
package mcd_pkg;

	// Command codes carried with every input transaction.
	localparam logic [1:0] CMD_RUN      = 2'd0;
	localparam logic [1:0] CMD_WRITE_MEM = 2'd1;
	localparam logic [1:0] CMD_SET_PC   = 2'd2;

	// Control word bit positions.
	localparam int CW_IRD        = 34;
	localparam int CW_COND_LO    = 32;
	localparam int CW_J_LO       = 26;
	localparam int CW_LD_MAR     = 25;
	localparam int CW_LD_MDR     = 24;
	localparam int CW_LD_IR      = 23;
	localparam int CW_LD_BEN     = 22;
	localparam int CW_LD_REG     = 21;
	localparam int CW_LD_CC      = 20;
	localparam int CW_LD_PC      = 19;
	localparam int CW_GATE_PC    = 18;
	localparam int CW_GATE_MDR   = 17;
	localparam int CW_GATE_ALU   = 16;
	localparam int CW_GATE_MARMUX = 15;
	localparam int CW_GATE_SHF   = 14;
	localparam int CW_PCMUX_LO   = 12;
	localparam int CW_DRMUX      = 11;
	localparam int CW_SR1MUX     = 10;
	localparam int CW_ADDR1MUX   = 9;
	localparam int CW_ADDR2MUX_LO = 7;
	localparam int CW_MARMUX     = 6;
	localparam int CW_ALUK_LO    = 4;
	localparam int CW_MIO_EN     = 3;
	localparam int CW_R_W        = 2;
	localparam int CW_DATA_SIZE  = 1;
	localparam int CW_LSHF1      = 0;

	// Microsequencer branch conditions.
	localparam logic [1:0] COND_READY = 2'd1;
	localparam logic [1:0] COND_BEN   = 2'd2;
	localparam logic [1:0] COND_IR11  = 2'd3;

	// Second address adder operand select.
	localparam logic [1:0] ADDR2_ZERO  = 2'd0;
	localparam logic [1:0] ADDR2_OFF6  = 2'd1;
	localparam logic [1:0] ADDR2_OFF9  = 2'd2;
	localparam logic [1:0] ADDR2_OFF11 = 2'd3;

	// ALU operations.
	localparam logic [1:0] ALU_ADD  = 2'd0;
	localparam logic [1:0] ALU_AND  = 2'd1;
	localparam logic [1:0] ALU_XOR  = 2'd2;
	localparam logic [1:0] ALU_PASS = 2'd3;

	// Shift modes taken from IR bits 5:4.
	localparam logic [1:0] SHF_LEFT  = 2'd0;
	localparam logic [1:0] SHF_RIGHT_LOG = 2'd1;
	localparam logic [1:0] SHF_RIGHT_ARITH = 2'd3;

	// Program counter source select.
	localparam logic [1:0] PC_PLUS2 = 2'd0;
	localparam logic [1:0] PC_BUS   = 2'd1;
	localparam logic [1:0] PC_ADDER = 2'd2;

	// Condition code patterns, N in bit 2, Z in bit 1, P in bit 0.
	localparam logic [2:0] CC_NEG  = 3'b100;
	localparam logic [2:0] CC_ZERO = 3'b010;
	localparam logic [2:0] CC_POS  = 3'b001;

	// Number of general registers and width of their index.
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = 3;

	// Fixed masks used by the byte paths.
	localparam logic [15:0] MASK_HI_BYTE = 16'hFF00;
	localparam logic [15:0] MASK_LO_BYTE = 16'h00FF;

	// One input transaction.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [34:0] control_word;
		logic [14:0] load_addr;
		logic [15:0] load_data;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [5:0]  next_micro_address;
		logic [15:0] bus_value;
		logic [15:0] pc_value;
		logic        memory_ready;
		logic        access_error;
		logic        pc_is_zero;
	} rsp_t;

endpackage

// File: rtl/mcd_if.sv
// Valid/ready channel interfaces for the request and result transactions.
interface mcd_req_if;
	logic            valid;
	logic            ready;
	mcd_pkg::req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mcd_rsp_if;
	logic            valid;
	logic            ready;
	mcd_pkg::rsp_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/mcd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/microcoded_cpu_datapath_cycle_unit.sv
// Top level of the microcoded 16-bit datapath: one machine cycle per request transaction.
//
// Each request transaction runs one machine cycle under the supplied control word, writes
// one memory word, or sets the program counter, and returns one result transaction. A new
// request is taken every clock while no result waits in the output register or that result
// is taken in the same cycle; each result is registered in the output register. Main memory
// is a single synchronous RAM whose read address is steered by the next MAR value, so the
// word under MAR is always ready when an access completes; a write to the word being read
// is forwarded. After reset a clearing pass writes zero to every memory word, during which
// no request is accepted.
module microcoded_cpu_datapath_cycle_unit #(
	parameter int MEM_WORDS   = 32768,
	parameter int MEM_LATENCY = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	mcd_req_if.sink   req,
	mcd_rsp_if.source rsp
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int PW = $clog2(MEM_LATENCY + 1);
	localparam int QSTEPS = $clog2((32768 + MEM_WORDS - 1) / MEM_WORDS);
	localparam logic [15:0] WORDS16 = 16'(MEM_WORDS);

	// Reduce a 15-bit word address into the memory range by conditional subtraction.
	function automatic logic [AW-1:0] mod_words(input logic [14:0] x);
		logic [15:0] r;
		r = {1'b0, x};
		for (int b = QSTEPS - 1; b >= 0; b--) begin
			if (r >= (WORDS16 << b)) begin
				r = r - (WORDS16 << b);
			end
		end
		return r[AW-1:0];
	endfunction

	// Architectural state.
	logic [15:0]   pc_q;
	logic [15:0]   ir_q;
	logic [15:0]   mar_q;
	logic [15:0]   mdr_q;
	logic [15:0]   regs_q [mcd_pkg::REG_COUNT];
	logic [2:0]    cc_q;
	logic          ben_q;
	logic          ready_q;
	logic [PW-1:0] phase_q;
	logic [15:0]   hold_q;

	// Memory clearing, read forwarding and output register.
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          fwd_valid_q;
	logic [15:0]   fwd_q;
	logic          out_valid_q;
	mcd_pkg::rsp_t out_q;

	// Combinational datapath signals.
	logic          accept;
	logic          run;
	logic          wr_cmd;
	logic          set_pc;
	logic [34:0]   cw;
	logic          ds;
	logic          mio;
	logic          odd;
	logic          mem_act;
	logic          mem_err;
	logic          mem_wr;
	logic [15:0]   mem_rd;
	logic [15:0]   mem_wword;
	logic [15:0]   hold_next;
	logic [15:0]   sr1;
	logic [15:0]   sr2;
	logic [15:0]   addr1;
	logic [15:0]   addr2;
	logic [15:0]   adder;
	logic [15:0]   marmux;
	logic [15:0]   alu;
	logic [15:0]   shf;
	logic [15:0]   mdr_path;
	logic [15:0]   bus;
	logic          err;
	logic [5:0]    nma;
	logic [15:0]   pc_next;
	logic [15:0]   mar_next;
	logic          ready_next;
	logic [PW-1:0] phase_next;
	logic [2:0]    dr;

	// Memory port signals.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	// Handshake and command decode.
	assign req.ready = !clearing_q && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign run       = accept && (req.payload.cmd == mcd_pkg::CMD_RUN);
	assign wr_cmd    = accept && (req.payload.cmd == mcd_pkg::CMD_WRITE_MEM);
	assign set_pc    = accept && (req.payload.cmd == mcd_pkg::CMD_SET_PC);
	assign cw        = req.payload.control_word;
	assign ds        = cw[mcd_pkg::CW_DATA_SIZE];
	assign mio       = cw[mcd_pkg::CW_MIO_EN];
	assign odd       = mar_q[0];

	// Memory word under MAR, with forwarding of a write made in the previous cycle.
	assign mem_rd = fwd_valid_q ? fwd_q : ram_rdata;

	// Memory handshake: the access completes one phase before the end of the sequence.
	always_comb begin
		mem_act    = 1'b0;
		ready_next = ready_q;
		phase_next = phase_q;
		if (run && mio) begin
			if (phase_q >= PW'(MEM_LATENCY)) begin
				phase_next = PW'(1);
				ready_next = 1'b0;
			end else begin
				if (phase_q == PW'(MEM_LATENCY - 1)) begin
					mem_act    = 1'b1;
					ready_next = 1'b1;
				end
				phase_next = phase_q + PW'(1);
			end
		end
	end

	assign mem_err = mem_act && odd && ds;
	assign mem_wr  = mem_act && !mem_err && cw[mcd_pkg::CW_R_W];

	// Word written back on a store: full word or one merged byte.
	always_comb begin
		if (ds) begin
			mem_wword = mdr_q;
		end else if (odd) begin
			mem_wword = (mem_rd & mcd_pkg::MASK_LO_BYTE) | (mdr_q & mcd_pkg::MASK_HI_BYTE);
		end else begin
			mem_wword = (mem_rd & mcd_pkg::MASK_HI_BYTE) | (mdr_q & mcd_pkg::MASK_LO_BYTE);
		end
	end

	// Read holding register takes the word, or only its high byte for odd addresses.
	always_comb begin
		hold_next = hold_q;
		if (mem_act && !mem_err && !cw[mcd_pkg::CW_R_W]) begin
			hold_next = odd ? (mem_rd & mcd_pkg::MASK_HI_BYTE) : mem_rd;
		end
	end

	// Microsequencer.
	always_comb begin
		if (cw[mcd_pkg::CW_IRD]) begin
			nma = {2'b00, ir_q[15:12]};
		end else begin
			nma = cw[mcd_pkg::CW_J_LO +: 6];
			case (cw[mcd_pkg::CW_COND_LO +: 2])
				mcd_pkg::COND_READY: nma[1] = nma[1] | ready_q;
				mcd_pkg::COND_BEN:   nma[2] = nma[2] | ben_q;
				mcd_pkg::COND_IR11:  nma[0] = nma[0] | ir_q[11];
				default:             nma = cw[mcd_pkg::CW_J_LO +: 6];
			endcase
		end
	end

	// Address adder and MAR mux.
	always_comb begin
		sr1   = cw[mcd_pkg::CW_SR1MUX] ? regs_q[ir_q[8:6]] : regs_q[ir_q[11:9]];
		addr1 = cw[mcd_pkg::CW_ADDR1MUX] ? sr1 : pc_q;
		case (cw[mcd_pkg::CW_ADDR2MUX_LO +: 2])
			mcd_pkg::ADDR2_ZERO:  addr2 = 16'h0000;
			mcd_pkg::ADDR2_OFF6:  addr2 = {{10{ir_q[5]}}, ir_q[5:0]};
			mcd_pkg::ADDR2_OFF9:  addr2 = {{7{ir_q[8]}}, ir_q[8:0]};
			mcd_pkg::ADDR2_OFF11: addr2 = {{5{ir_q[10]}}, ir_q[10:0]};
			default:              addr2 = 16'h0000;
		endcase
		adder  = addr1 + (cw[mcd_pkg::CW_LSHF1] ? {addr2[14:0], 1'b0} : addr2);
		marmux = cw[mcd_pkg::CW_MARMUX] ? adder : {7'b0, ir_q[7:0], 1'b0};
	end

	// ALU and shifter.
	always_comb begin
		sr2 = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : regs_q[ir_q[2:0]];
		case (cw[mcd_pkg::CW_ALUK_LO +: 2])
			mcd_pkg::ALU_ADD:  alu = sr1 + sr2;
			mcd_pkg::ALU_AND:  alu = sr1 & sr2;
			mcd_pkg::ALU_XOR:  alu = sr1 ^ sr2;
			mcd_pkg::ALU_PASS: alu = sr1;
			default:           alu = sr1;
		endcase
		case (ir_q[5:4])
			mcd_pkg::SHF_LEFT:        shf = sr1 << ir_q[3:0];
			mcd_pkg::SHF_RIGHT_LOG:   shf = sr1 >> ir_q[3:0];
			mcd_pkg::SHF_RIGHT_ARITH: shf = 16'($signed(sr1) >>> ir_q[3:0]);
			default:                  shf = 16'h0000;
		endcase
	end

	// MDR path: full word, or the addressed byte sign-extended.
	always_comb begin
		if (ds) begin
			mdr_path = mdr_q;
		end else if (odd) begin
			mdr_path = {{8{mdr_q[15]}}, mdr_q[15:8]};
		end else begin
			mdr_path = {{8{mdr_q[7]}}, mdr_q[7:0]};
		end
	end

	// Bus gate in priority order, and the access error flag.
	always_comb begin
		bus = 16'h0000;
		err = 1'b0;
		if (run) begin
			err = mem_err;
			if (cw[mcd_pkg::CW_GATE_PC]) begin
				bus = pc_q;
			end else if (cw[mcd_pkg::CW_GATE_MDR]) begin
				bus = mdr_path;
				if (odd && ds) begin
					err = 1'b1;
				end
			end else if (cw[mcd_pkg::CW_GATE_ALU]) begin
				bus = alu;
			end else if (cw[mcd_pkg::CW_GATE_MARMUX]) begin
				bus = marmux;
			end else if (cw[mcd_pkg::CW_GATE_SHF]) begin
				bus = shf;
			end
		end
	end

	// Next PC and MAR.
	always_comb begin
		pc_next = pc_q;
		if (set_pc) begin
			pc_next = req.payload.load_data;
		end else if (run && cw[mcd_pkg::CW_LD_PC]) begin
			case (cw[mcd_pkg::CW_PCMUX_LO +: 2])
				mcd_pkg::PC_PLUS2: pc_next = pc_q + 16'd2;
				mcd_pkg::PC_BUS:   pc_next = bus;
				mcd_pkg::PC_ADDER: pc_next = adder;
				default:           pc_next = pc_q;
			endcase
		end
		mar_next = (run && cw[mcd_pkg::CW_LD_MAR]) ? bus : mar_q;
		dr = cw[mcd_pkg::CW_DRMUX] ? 3'd7 : ir_q[11:9];
	end

	// Memory port steering: clearing pass, host write or datapath store.
	always_comb begin
		ram_raddr = mod_words(mar_next[15:1]);
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 16'h0000;
		end else if (wr_cmd) begin
			ram_we    = 1'b1;
			ram_waddr = mod_words(req.payload.load_addr);
			ram_wdata = req.payload.load_data;
		end else begin
			ram_we    = mem_wr;
			ram_waddr = mod_words(mar_q[15:1]);
			ram_wdata = mem_wword;
		end
	end

	mcd_ram #(
		.WIDTH (16),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Clearing pass and read forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MEM_WORDS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			fwd_valid_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= ram_wdata;
	end

	// Architectural register update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			ir_q    <= '0;
			mar_q   <= '0;
			mdr_q   <= '0;
			for (int i = 0; i < mcd_pkg::REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
			cc_q    <= mcd_pkg::CC_ZERO;
			ben_q   <= 1'b0;
			ready_q <= 1'b0;
			phase_q <= PW'(1);
			hold_q  <= '0;
		end else begin
			pc_q    <= pc_next;
			mar_q   <= mar_next;
			ready_q <= ready_next;
			phase_q <= phase_next;
			hold_q  <= hold_next;
			if (run) begin
				if (cw[mcd_pkg::CW_LD_MDR]) begin
					if (mio) begin
						mdr_q <= hold_next;
					end else if (ds) begin
						mdr_q <= bus;
					end else begin
						mdr_q <= {bus[7:0], bus[7:0]};
					end
				end
				if (cw[mcd_pkg::CW_LD_IR]) begin
					ir_q <= bus;
				end
				if (cw[mcd_pkg::CW_LD_REG]) begin
					regs_q[dr] <= bus;
				end
				if (cw[mcd_pkg::CW_LD_BEN]) begin
					ben_q <= (cc_q[2] & ir_q[11]) | (cc_q[1] & ir_q[10]) | (cc_q[0] & ir_q[9]);
				end
				if (cw[mcd_pkg::CW_LD_CC]) begin
					if (bus == 16'h0000) begin
						cc_q <= mcd_pkg::CC_ZERO;
					end else if (bus[15]) begin
						cc_q <= mcd_pkg::CC_NEG;
					end else begin
						cc_q <= mcd_pkg::CC_POS;
					end
				end
			end
		end
	end

	// Output register; a new result replaces one that is taken in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.next_micro_address <= run ? nma : 6'd0;
			out_q.bus_value          <= bus;
			out_q.pc_value           <= pc_next;
			out_q.memory_ready       <= ready_next;
			out_q.access_error       <= err;
			out_q.pc_is_zero         <= (pc_next == 16'h0000);
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

`ifndef NO_ASSERTIONS
	// No transaction is taken while the memory is being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.ready)
		else $error("request accepted during memory clearing");

	// The handshake phase stays within its sequence.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) && (phase_q <= PW'(MEM_LATENCY)))
		else $error("memory phase out of range");

	// Ready is raised only by a completing access, which leaves the phase at its end.
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> (phase_q == PW'(MEM_LATENCY)))
		else $error("ready raised outside the last phase");

	// A forwarded word always comes from a write in the previous cycle.
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> $past(ram_we))
		else $error("forwarding without a write");
`endif

endmodule
